[rtl/unsorted_array_table_engine_core_defines.svh]
// Assertion macros used by the table engine RTL.
`ifndef UNSORTED_ARRAY_TABLE_ENGINE_CORE_DEFINES_SVH
`define UNSORTED_ARRAY_TABLE_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define UATBL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("table engine check failed");

// Next-cycle implication
`define UATBL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("table engine check failed");

`else

`define UATBL_ASSERT_IMP(label, clk, rst, ante, cons)
`define UATBL_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/uatbl_pkg.sv]
package uatbl_pkg;

   // Default sizing
   localparam int CAPACITY_DEF    = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   // Fixed port widths
   localparam int OPCODE_W   = 2;
   localparam int ITEM_W     = 32;
   localparam int POS_W      = 5;
   localparam int STATUS_W   = 2;
   localparam int MIDX_W     = 4;
   localparam int ECOUNT_W   = 5;
   localparam int CAP_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Register map, indexed by word address
   typedef enum logic [0:0] {
      CSR_CAPACITY = 1'b0
   } csr_idx_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_FIND   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_POS   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_RESULT
   } state_type;

   // Broadcast control to every cell of the chain
   typedef struct packed {
      logic cmp;        // latch per-cell compare
      logic load_tok;   // place scan token in cell 0
      logic shift_tok;  // move scan token one cell up
      logic ins;        // open a gap at sel and write the value
      logic del;        // close the gap at sel
   } cell_ctl_type;

endpackage

[rtl/uatbl_cell.sv]
module uatbl_cell #(
   parameter int CAPACITY    = uatbl_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = uatbl_pkg::VALUE_WIDTH_DEF,
   parameter int INDEX       = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  uatbl_pkg::cell_ctl_type          ctl,
   input  logic [$clog2(CAPACITY)-1:0]      sel_idx,
   input  logic [$clog2(CAPACITY+1)-1:0]    count,
   input  logic [VALUE_WIDTH-1:0]           value,
   input  logic [VALUE_WIDTH-1:0]           left_entry,
   input  logic [VALUE_WIDTH-1:0]           right_entry,
   input  logic                             left_tok,
   output logic [VALUE_WIDTH-1:0]           entry,
   output logic                             tok,
   output logic                             hit
);
   import uatbl_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

   logic [VALUE_WIDTH-1:0] entry_ff, entry_in;
   logic                   match_ff, match_in;
   logic                   tok_ff, tok_in;

   // Entry: hold, take a neighbour's entry, or load the new value
   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins) begin
         if (MY_IDX == sel_idx) begin
            entry_in = value;
         end else if (MY_IDX > sel_idx) begin
            entry_in = left_entry;
         end
      end else if (ctl.del) begin
         if (MY_IDX >= sel_idx) begin
            entry_in = right_entry;
         end
      end
   end

   // Compare against the query, only for occupied slots
   assign match_in = ctl.cmp ? ((entry_ff == value) && (MY_CNT < count)) : match_ff;

   // Scan token walks up the chain one cell a cycle
   always_comb begin
      tok_in = tok_ff;
      if (ctl.load_tok) begin
         tok_in = (INDEX == 0);
      end else if (ctl.shift_tok) begin
         tok_in = left_tok;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         match_ff <= match_in;
         tok_ff   <= tok_in;
      end
   end

   assign entry = entry_ff;
   assign tok   = tok_ff;
   assign hit   = tok_ff & match_ff;

endmodule

[rtl/uatbl_ctrl.sv]
module uatbl_ctrl #(
   parameter int CAPACITY    = uatbl_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = uatbl_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [uatbl_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic signed [uatbl_pkg::ITEM_W-1:0]    req_item_value,
   input  logic [uatbl_pkg::POS_W-1:0]            req_position,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [uatbl_pkg::STATUS_W-1:0]         rsp_status,
   output logic [uatbl_pkg::MIDX_W-1:0]           rsp_match_index,
   output logic [uatbl_pkg::ECOUNT_W-1:0]         rsp_entry_count,
   input  logic [uatbl_pkg::CAP_W-1:0]            cap,
   input  logic                                   hit_any,
   output uatbl_pkg::cell_ctl_type                ctl,
   output logic [$clog2(CAPACITY)-1:0]            sel_idx,
   output logic [$clog2(CAPACITY+1)-1:0]          count,
   output logic [VALUE_WIDTH-1:0]                 value
);
   import uatbl_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   state_type               state_ff, state_in;
   logic [OPCODE_W-1:0]     op_ff, op_in;
   logic [VALUE_WIDTH-1:0]  val_ff, val_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        cursor_ff, cursor_in;
   status_type              status_ff, status_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [MIDX_W-1:0]       rsp_midx_ff, rsp_midx_in;
   logic [ECOUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic [CMP_W-1:0]        pos_w, count_w;
   logic                    is_full, bad_pos, last_slot, rsp_load;

   assign pos_w     = CMP_W'(pos_ff);
   assign count_w   = CMP_W'(count_ff);
   assign is_full   = (count_w >= CMP_W'(cap)) || (count_ff == CNT_FULL);
   assign bad_pos   = (pos_w == '0) || (pos_w > (count_w + 1'b1));
   assign last_slot = ((CNT_W'(cursor_ff) + 1'b1) == count_ff);
   assign rsp_load  = (state_ff == S_RESULT) && (!rsp_valid_ff || rsp_ready);

   // Sequencer: capture, execute, token scan, hand result to output register
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      status_in = status_ff;
      idx_in    = idx_ff;
      ctl       = '0;
      sel_idx   = cursor_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_opcode;
               val_in   = VALUE_WIDTH'(req_item_value);
               pos_in   = req_position;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            idx_in    = '0;
            unique case (op_ff)
               OP_INSERT: begin
                  state_in = S_RESULT;
                  sel_idx  = IDX_W'(pos_w - 1'b1);
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else if (bad_pos) begin
                     status_in = ST_BAD_POS;
                  end else begin
                     ctl.ins  = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_FIND, OP_DELETE: begin
                  ctl.cmp      = 1'b1;
                  ctl.load_tok = 1'b1;
                  cursor_in    = '0;
                  if (count_ff == '0) begin
                     status_in = ST_NOT_FOUND;
                     state_in  = S_RESULT;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_RESULT;
               end
            endcase
         end
         S_SCAN: begin
            if (hit_any) begin
               idx_in   = cursor_ff;
               state_in = S_RESULT;
               if (op_ff == OP_DELETE) begin
                  ctl.del  = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end else if (last_slot) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESULT;
            end else begin
               ctl.shift_tok = 1'b1;
               cursor_in     = cursor_ff + 1'b1;
            end
         end
         S_RESULT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_midx_in   = rsp_midx_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_midx_in   = MIDX_W'(idx_ff);
         rsp_count_in  = ECOUNT_W'(count_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      cursor_ff     <= cursor_in;
      status_ff     <= status_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_midx_ff   <= rsp_midx_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_index = rsp_midx_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign count           = count_ff;
   assign value           = val_ff;

endmodule

[rtl/unsorted_array_table_engine_core.sv]
// Channel   Direction  Beat carries
// req       in         opcode, item_value, position
// rsp       out        status, match_index, entry_count
// csr       in/out     APB write/read of capacity_in_use (byte address 0)
//
// Insert and no-op: S_EXEC passes to S_RESULT, which loads the result register.
// Find and delete: S_EXEC, then S_SCAN over the slots scanned (1 to count, none when
//   empty), then S_RESULT; the scan token moves one cell of the chain per cycle.
// One item at a time; req_ready is high only while the sequencer is idle.
// A pending result stalls the sequencer until rsp_ready takes it.
// Synchronous reset empties the table and sets capacity_in_use to 16.
module unsorted_array_table_engine_core #(
   parameter int CAPACITY    = uatbl_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = uatbl_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [uatbl_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic signed [uatbl_pkg::ITEM_W-1:0]    req_item_value,
   input  logic [uatbl_pkg::POS_W-1:0]            req_position,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [uatbl_pkg::STATUS_W-1:0]         rsp_status,
   output logic [uatbl_pkg::MIDX_W-1:0]           rsp_match_index,
   output logic [uatbl_pkg::ECOUNT_W-1:0]         rsp_entry_count,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [uatbl_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [uatbl_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [uatbl_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                   csr_pready
);
   import uatbl_pkg::*;

`include "unsorted_array_table_engine_core_defines.svh"

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CAP_W-1:0]        cap_ff, cap_in;
   logic                    csr_wr, csr_hit;
   cell_ctl_type            ctl;
   logic [IDX_W-1:0]        sel_idx;
   logic [CNT_W-1:0]        count;
   logic [VALUE_WIDTH-1:0]  value;
   logic [VALUE_WIDTH-1:0]  entry_q [CAPACITY];
   logic [CAPACITY-1:0]     tok_q;
   logic [CAPACITY-1:0]     hit_vec;
   logic                    hit_any;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_CAPACITY);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cap_in     = (csr_wr && csr_hit) ? csr_pwdata[CAP_W-1:0] : cap_ff;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // Sequencer
   uatbl_ctrl #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_item_value  (req_item_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_match_index (rsp_match_index),
      .rsp_entry_count (rsp_entry_count),
      .cap             (cap_ff),
      .hit_any         (hit_any),
      .ctl             (ctl),
      .sel_idx         (sel_idx),
      .count           (count),
      .value           (value)
   );

   // Chain of entry cells
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_e, right_e;
      logic                   left_t;

      if (gi == 0) begin : g_first
         assign left_e = value;
         assign left_t = 1'b0;
      end else begin : g_mid
         assign left_e = entry_q[gi-1];
         assign left_t = tok_q[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
         assign right_e = entry_q[gi];
      end else begin : g_inner
         assign right_e = entry_q[gi+1];
      end

      uatbl_cell #(
         .CAPACITY    (CAPACITY),
         .VALUE_WIDTH (VALUE_WIDTH),
         .INDEX       (gi)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .sel_idx     (sel_idx),
         .count       (count),
         .value       (value),
         .left_entry  (left_e),
         .right_entry (right_e),
         .left_tok    (left_t),
         .entry       (entry_q[gi]),
         .tok         (tok_q[gi]),
         .hit         (hit_vec[gi])
      );
   end

   assign hit_any = |hit_vec;

   // Checks
   `UATBL_ASSERT_IMP(a_single_hit, clock, reset, 1'b1, $onehot0(hit_vec))
   `UATBL_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count <= CNT_W'(CAPACITY))
   `UATBL_ASSERT_IMP(a_del_on_hit, clock, reset, ctl.del, hit_any)
   `UATBL_ASSERT_NXT(a_ins_grows, clock, reset, ctl.ins, count == $past(count) + 1'b1)

endmodule

[dv/unsorted_array_table_engine_core_tb.sv]
module unsorted_array_table_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import uatbl_pkg::*;

   localparam int TABLE_DEPTH = CAPACITY_DEF;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 3 + TABLE_DEPTH + 8;
   localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR = CSR_ADDR_W'(4 * CSR_CAPACITY);
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CAP_ADDR + CSR_ADDR_W'(4);
   localparam logic signed [ITEM_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [ITEM_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      status_type          status;
      logic [MIDX_W-1:0]   index;
      logic [ECOUNT_W-1:0] count;
   } table_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [OPCODE_W-1:0]        req_opcode = '0;
   logic signed [ITEM_W-1:0]   req_item_value = '0;
   logic [POS_W-1:0]           req_position = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [MIDX_W-1:0]          rsp_match_index;
   logic [ECOUNT_W-1:0]        rsp_entry_count;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      csr_paddr = '0;
   logic [CSR_DATA_W-1:0]      csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]      csr_prdata;
   logic                       csr_pready;

   // Shadow of the table contents and capacity register
   logic signed [ITEM_W-1:0] table_vals [TABLE_DEPTH];
   int                       table_count = 0;
   logic [CAP_W-1:0]         cap_shadow = CAP_RESET;

   table_reply_type table_replies_due[$];
   table_reply_type due_reply;

   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_cycles = 0;
   int ops_sent = 0;
   int replies_checked = 0;
   int cap_writes = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   unsorted_array_table_engine_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_item_value  (req_item_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_match_index (rsp_match_index),
      .rsp_entry_count (rsp_entry_count),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d replies still due", $time, table_replies_due.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Applies one operation to the shadow table and returns the reply it gives
   function automatic table_reply_type apply_table_op(logic [OPCODE_W-1:0] op,
                                                      logic signed [ITEM_W-1:0] val,
                                                      logic [POS_W-1:0] pos);
      table_reply_type r;
      int lim;
      int hit;
      int p;
      int i;
      r.status = ST_OK;
      r.index = '0;
      lim = (cap_shadow > TABLE_DEPTH) ? TABLE_DEPTH : int'(cap_shadow);
      p = int'(pos);
      hit = -1;
      for (i = 0; i < table_count; i++)
         if (hit < 0 && table_vals[i] == val) hit = i;
      case (op)
         OP_FIND: begin
            if (hit < 0) r.status = ST_NOT_FOUND;
            else r.index = MIDX_W'(hit);
         end
         OP_INSERT: begin
            // full is checked ahead of the position
            if (table_count >= lim) r.status = ST_FULL;
            else if (p < 1 || p > table_count + 1) r.status = ST_BAD_POS;
            else begin
               for (i = table_count; i >= p; i--) table_vals[i] = table_vals[i-1];
               table_vals[p-1] = val;
               table_count++;
            end
         end
         OP_DELETE: begin
            if (hit < 0) r.status = ST_NOT_FOUND;
            else begin
               r.index = MIDX_W'(hit);
               for (i = hit; i + 1 < table_count; i++) table_vals[i] = table_vals[i+1];
               table_count--;
            end
         end
         default: ;
      endcase
      r.count = ECOUNT_W'(table_count);
      return r;
   endfunction

   // Sends one beat on req, with random gaps ahead of it
   task automatic send_item(logic [OPCODE_W-1:0] op, logic signed [ITEM_W-1:0] val,
                            logic [POS_W-1:0] pos);
      @(negedge clock);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = op;
      req_item_value = val;
      req_position = pos;
      do @(posedge clock); while (!req_ready);
      table_replies_due.push_back(apply_table_op(op, val, pos));
      ops_sent++;
   endtask

   // Sender stops until every reply is in and the block has settled
   task automatic quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      while (table_replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(logic wr, logic [CSR_ADDR_W-1:0] addr,
                             logic [CSR_DATA_W-1:0] wdata, output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = wr;
      csr_paddr = addr;
      csr_pwdata = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (wr && addr == CAP_ADDR) begin
         cap_shadow = wdata[CAP_W-1:0];
         cap_writes++;
      end
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Writes capacity with random upper bits, then reads it back
   task automatic set_capacity(logic [CAP_W-1:0] cap);
      logic [CSR_DATA_W-1:0] rd;
      logic [CSR_DATA_W-1:0] wd;
      quiesce();
      wd = {$urandom, cap};
      csr_access(1'b1, CAP_ADDR, wd, rd);
      check_capacity_readback();
   endtask

   task automatic check_capacity_readback();
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b0, CAP_ADDR, '0, rd);
      if (rd !== CSR_DATA_W'(cap_shadow)) begin
         $display("%0t: capacity readback expected %0d actual %0d", $time, cap_shadow, rd);
         mismatch_count++;
      end
   endtask

   // Values already in the table about a third of the time, so finds and deletes can hit
   function automatic logic signed [ITEM_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (table_count > 0 && r < 35) return table_vals[$urandom_range(table_count - 1)];
      if (r < 45) return VAL_MIN;
      if (r < 55) return VAL_MAX;
      if (r < 75) return ITEM_W'(int'($urandom_range(3)) - 1);
      return $urandom;
   endfunction

   task automatic send_random_op(int ins_pct);
      logic [OPCODE_W-1:0] op;
      logic [POS_W-1:0] pos;
      int r;
      r = $urandom_range(99);
      if (r < 4) op = OP_NOP;
      else if (r < 4 + ins_pct) op = OP_INSERT;
      else if (r[0]) op = OP_FIND;
      else op = OP_DELETE;
      if ($urandom_range(99) < 80) pos = POS_W'($urandom_range(table_count + 1, 1));
      else pos = POS_W'($urandom_range(31));
      send_item(op, pick_value(), pos);
   endtask

   // Reply checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (table_replies_due.size() == 0) begin
            $display("%0t: unexpected reply status %0d index %0d count %0d", $time,
                     rsp_status, rsp_match_index, rsp_entry_count);
            mismatch_count++;
         end else begin
            due_reply = table_replies_due.pop_front();
            replies_checked++;
            if (rsp_status !== due_reply.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        due_reply.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_match_index !== due_reply.index) begin
               $display("%0t: match_index expected %0d actual %0d", $time,
                        due_reply.index, rsp_match_index);
               mismatch_count++;
            end
            if (rsp_entry_count !== due_reply.count) begin
               $display("%0t: entry_count expected %0d actual %0d", $time,
                        due_reply.count, rsp_entry_count);
               mismatch_count++;
            end
         end
      end
   end

   // Receiver: long hold-off when asked, else random stalls
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready = 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic test_register_map();
      logic [CSR_DATA_W-1:0] rd;
      check_capacity_readback();
      // write beyond the register list must be dropped
      csr_access(1'b1, SPARE_ADDR, 32'h0000_0003, rd);
      check_capacity_readback();
   endtask

   task automatic test_directed_ops();
      send_item(OP_FIND, 32'sd0, 5'd1);
      send_item(OP_DELETE, 32'sd0, 5'd1);
      send_item(OP_NOP, -32'sd1, 5'd31);
      send_item(OP_INSERT, 32'sd5, 5'd0);
      send_item(OP_INSERT, 32'sd5, 5'd2);
      send_item(OP_INSERT, VAL_MAX, 5'd1);
      send_item(OP_INSERT, VAL_MIN, 5'd1);
      send_item(OP_INSERT, 32'sd0, 5'd3);
      send_item(OP_INSERT, -32'sd1, 5'd2);
      send_item(OP_INSERT, VAL_MAX, 5'd5);
      send_item(OP_INSERT, 32'sd7, 5'd31);
      send_item(OP_FIND, VAL_MAX, 5'd0);
      send_item(OP_FIND, VAL_MIN, 5'd16);
      send_item(OP_FIND, 32'sh1234_5678, 5'd1);
      send_item(OP_DELETE, VAL_MAX, 5'd1);
      send_item(OP_FIND, VAL_MAX, 5'd1);
      send_item(OP_DELETE, 32'sd99, 5'd1);
      send_item(OP_DELETE, VAL_MIN, 5'd1);
   endtask

   task automatic test_capacity_limits();
      // lowered below the count: full, and full wins over a bad position
      set_capacity(5'd2);
      send_item(OP_INSERT, 32'sd11, 5'd1);
      send_item(OP_INSERT, 32'sd11, 5'd0);
      set_capacity(5'd0);
      send_item(OP_INSERT, 32'sd12, 5'd1);
      send_item(OP_FIND, -32'sd1, 5'd1);
      // above the table size saturates at the table size
      set_capacity(5'd31);
      send_item(OP_INSERT, 32'sd13, 5'd4);
      send_item(OP_FIND, 32'sd13, 5'd1);
   endtask

   task automatic test_random_phase(int gap_pct, int stall_pct, logic [CAP_W-1:0] cap,
                                    int ins_pct, int n);
      set_capacity(cap);
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      repeat (n) send_random_op(ins_pct);
   endtask

   task automatic test_reply_backpressure();
      set_capacity(5'd16);
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      @(posedge clock);
      rsp_hold_cycles = 200;
      repeat (30) send_random_op(45);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_register_map();
      test_directed_ops();
      test_capacity_limits();
      test_random_phase(0, 0, 5'd31, 60, 240);
      test_random_phase(61, 0, 5'd1, 50, 240);
      test_random_phase(0, 61, 5'd16, 30, 240);
      test_random_phase(33, 33, 5'd9, 55, 240);
      test_reply_backpressure();
      quiesce();

      $display("Covered %0d table beats over %0d capacity writes, %0d replies checked",
               ops_sent, cap_writes, replies_checked);
      $display("Idle profiles: none, sender gaps, receiver stalls, both, long reply hold-off");
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/uatbl_pkg.sv
rtl/uatbl_cell.sv
rtl/uatbl_ctrl.sv
rtl/unsorted_array_table_engine_core.sv
dv/unsorted_array_table_engine_core_tb.sv
